>>> hdl/mpfb_pkg.sv
// Shared types, constants and the digit glyph table of the page-mode framebuffer draw unit.
`timescale 1ns / 1ps

package mpfb_pkg;

   // Default panel geometry
   localparam int FB_WIDTH_DEF  = 128;
   localparam int FB_HEIGHT_DEF = 64;

   // Glyph geometry and accepted character range
   localparam int         GLYPH_COLS = 6;
   localparam logic [7:0] CODE_ZERO  = 8'h30;
   localparam logic [7:0] CODE_NINE  = 8'h39;

   // Command kinds
   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_DIGIT = 2'd1;
   localparam logic [1:0] KIND_BAR   = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_WIPE,
      ST_IDLE,
      ST_LOOK,
      ST_MERGE,
      ST_FETCH,
      ST_DONE
   } state_type;

   // Current position of the column/page walk
   typedef struct packed {
      logic       is_digit;
      logic [3:0] digit;
      logic [5:0] page;
      logic [7:0] col;
      logic [7:0] x;
      logic [8:0] y_lo;
      logic [8:0] y_hi;
   } walk_type;

   // Byte produced for the current walk position
   typedef struct packed {
      logic       page_ok;
      logic       in_range;
      logic [7:0] bits;
   } hit_type;

   // One 6x8 glyph column, bit 0 is the top row
   function automatic logic [7:0] glyph_col(input logic [3:0] digit, input logic [2:0] col);
      logic [47:0] row;
      logic [7:0]  res;
      case (digit)
         4'd0:    row = 48'h00_3E_45_49_51_3E;
         4'd1:    row = 48'h00_00_40_7F_42_00;
         4'd2:    row = 48'h00_46_49_51_61_42;
         4'd3:    row = 48'h00_31_4B_45_41_21;
         4'd4:    row = 48'h00_10_7F_12_14_18;
         4'd5:    row = 48'h00_39_45_45_45_27;
         4'd6:    row = 48'h00_30_49_49_4A_3C;
         4'd7:    row = 48'h00_03_05_09_71_01;
         4'd8:    row = 48'h00_36_49_49_49_36;
         4'd9:    row = 48'h00_1E_29_49_49_06;
         default: row = 48'h0;
      endcase
      if (int'(col) < GLYPH_COLS) begin
         res = row[{col, 3'b000} +: 8];
      end else begin
         res = 8'h00;
      end
      return res;
   endfunction

endpackage

>>> hdl/mpfb_byte_gen.sv
// Address and bit pattern generator for one framebuffer byte of a glyph or bar walk.
`timescale 1ns / 1ps

module mpfb_byte_gen
   import mpfb_pkg::*;
#(
   parameter int  FB_WIDTH  = FB_WIDTH_DEF,
   parameter int  FB_HEIGHT = FB_HEIGHT_DEF,
   localparam int FB_BYTES  = FB_WIDTH * FB_HEIGHT / 8,
   localparam int PAGES     = FB_HEIGHT / 8,
   localparam int ADDR_W    = $clog2(FB_BYTES),
   localparam int IDX_W     = $clog2(64 * FB_WIDTH + 512)
) (
   input  walk_type            walk,
   output hit_type             hit,
   output logic [ADDR_W-1:0]   addr
);

   logic [IDX_W-1:0] idx;
   logic [7:0]       bar_bits;
   logic [7:0]       glyph_bits;

   // Linear byte index: page * width + x + column, no wrap
   assign idx = IDX_W'(walk.page) * IDX_W'(FB_WIDTH) + IDX_W'(walk.x) + IDX_W'(walk.col);

   // Bar rows of this page that fall inside [y_lo, y_hi)
   always_comb begin
      logic [8:0] row;
      row = 9'd0;
      for (int b = 0; b < 8; b++) begin
         row         = {walk.page, 3'(b)};
         bar_bits[b] = (row >= walk.y_lo) && (row < walk.y_hi);
      end
   end

   // Glyph column shifted down inside its page, overflow dropped
   assign glyph_bits = glyph_col(walk.digit, walk.col[2:0]) << walk.y_lo[2:0];

   assign hit.page_ok  = int'(walk.page) < PAGES;
   assign hit.in_range = idx < IDX_W'(FB_BYTES);
   assign hit.bits     = walk.is_digit ? glyph_bits : bar_bits;
   assign addr         = idx[ADDR_W-1:0];

endmodule

>>> hdl/mono_page_framebuffer_draw_unit.sv
// Top level of the page-mode monochrome framebuffer draw unit.
`timescale 1ns / 1ps

// Keeps a FB_WIDTH x FB_HEIGHT monochrome framebuffer (FB_WIDTH*FB_HEIGHT/8 bytes, 1024 by
// default) in one single-port-write, single-port-read RAM and runs one command at a time,
// each answered by exactly one result. Every touched byte is a read-modify-write through the
// RAM, a lookup state then a merge state per byte in range and a lookup alone per byte index
// that falls outside the store. After reset, and for every clear command, the unit sweeps
// the whole RAM one byte per cycle with req_tready low. The result sits in an output
// register, so the next command is taken while an earlier result waits.
module mono_page_framebuffer_draw_unit
   import mpfb_pkg::*;
#(
   parameter int FB_WIDTH  = FB_WIDTH_DEF,
   parameter int FB_HEIGHT = FB_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // x_pos[7:0], y_pos[15:8], char_code[23:16], bar_width[31:24], bar_height[39:32],
   // bar_fill[47:40], read_address[57:48], zero pad [63:58]
   input  logic [63:0] req_tdata,
   // kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0]
   output logic [7:0]  rsp_tdata,
   // done_kind[1:0]
   output logic [1:0]  rsp_tuser
);

   localparam int FB_BYTES = FB_WIDTH * FB_HEIGHT / 8;
   localparam int ADDR_W   = $clog2(FB_BYTES);
   localparam int IDX_W    = $clog2(64 * FB_WIDTH + 512);

   // Request fields
   logic [7:0] req_x;
   logic [7:0] req_y;
   logic [7:0] req_code;
   logic [7:0] req_width;
   logic [7:0] req_height;
   logic [7:0] req_fill;
   logic [9:0] req_read_address;

   assign req_x            = req_tdata[7:0];
   assign req_y            = req_tdata[15:8];
   assign req_code         = req_tdata[23:16];
   assign req_width        = req_tdata[31:24];
   assign req_height       = req_tdata[39:32];
   assign req_fill         = req_tdata[47:40];
   assign req_read_address = req_tdata[57:48];

   // Control and command registers
   state_type         state_ff, state_in;
   logic              report_ff, report_in;
   logic [ADDR_W-1:0] wipe_ff, wipe_in;
   logic [1:0]        kind_ff, kind_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [7:0]        data_ff, data_in;
   logic [3:0]        digit_ff, digit_in;
   logic [7:0]        x_ff, x_in;
   logic [8:0]        lo_ff, lo_in;
   logic [8:0]        hi_ff, hi_in;
   logic [5:0]        page_ff, page_in;
   logic [5:0]        page_last_ff, page_last_in;
   logic [7:0]        col_ff, col_in;
   logic [7:0]        col_last_ff, col_last_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [7:0]        bits_ff, bits_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;

   // Frame RAM ports
   logic [7:0]        frame_mem [FB_BYTES];
   logic [7:0]        mem_q_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [7:0]        mem_wdata;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_raddr;

   // Decode helpers
   logic              req_fire;
   logic              slot_free;
   logic              digit_ok;
   logic [7:0]        fill_eff;
   logic [8:0]        bar_hi;
   logic              bar_empty;
   logic [IDX_W-1:0]  rd_idx;
   logic              rd_ok;
   logic              walk_last;
   logic              wipe_last;
   walk_type          walk;
   hit_type           hit;
   logic [ADDR_W-1:0] gen_addr;

   assign req_fire  = req_tvalid && req_tready;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign digit_ok  = (req_code >= CODE_ZERO) && (req_code <= CODE_NINE);
   assign fill_eff  = (req_fill > req_height) ? req_height : req_fill;
   assign bar_hi    = {1'b0, req_y} + {1'b0, fill_eff};
   assign bar_empty = (req_width == 8'd0) || (fill_eff == 8'd0);
   assign rd_idx    = IDX_W'(req_read_address);
   assign rd_ok     = rd_idx < IDX_W'(FB_BYTES);
   assign walk_last = (col_ff == col_last_ff) && (page_ff == page_last_ff);
   assign wipe_last = wipe_ff == ADDR_W'(FB_BYTES - 1);

   // Byte generator for the current walk position
   assign walk.is_digit = kind_ff == KIND_DIGIT;
   assign walk.digit    = digit_ff;
   assign walk.page     = page_ff;
   assign walk.col      = col_ff;
   assign walk.x        = x_ff;
   assign walk.y_lo     = lo_ff;
   assign walk.y_hi     = hi_ff;

   mpfb_byte_gen #(
      .FB_WIDTH  (FB_WIDTH),
      .FB_HEIGHT (FB_HEIGHT)
   ) u_byte_gen (
      .walk (walk),
      .hit  (hit),
      .addr (gen_addr)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_WIPE: begin
            if (wipe_last) begin
               state_in = report_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  KIND_CLEAR: state_in = ST_WIPE;
                  KIND_DIGIT: state_in = digit_ok ? ST_LOOK : ST_DONE;
                  KIND_BAR:   state_in = bar_empty ? ST_DONE : ST_LOOK;
                  KIND_READ:  state_in = ST_FETCH;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_LOOK: begin
            if (!hit.page_ok) begin
               state_in = ST_DONE;
            end else if (hit.in_range) begin
               state_in = ST_MERGE;
            end else if (walk_last) begin
               state_in = ST_DONE;
            end
         end
         ST_MERGE: begin
            state_in = walk_last ? ST_DONE : ST_LOOK;
         end
         ST_FETCH: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, RAM controls and handshake
   always_comb begin
      req_tready   = state_ff == ST_IDLE;
      report_in    = report_ff;
      wipe_in      = wipe_ff;
      kind_in      = kind_ff;
      rd_ok_in     = rd_ok_ff;
      data_in      = data_ff;
      digit_in     = digit_ff;
      x_in         = x_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      page_in      = page_ff;
      page_last_in = page_last_ff;
      col_in       = col_ff;
      col_last_in  = col_last_ff;
      addr_in      = addr_ff;
      bits_in      = bits_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      mem_we       = 1'b0;
      mem_waddr    = wipe_ff;
      mem_wdata    = 8'h00;
      mem_re       = 1'b0;
      mem_raddr    = gen_addr;

      case (state_ff)
         ST_WIPE: begin
            mem_we  = 1'b1;
            wipe_in = wipe_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               kind_in      = req_tuser;
               data_in      = 8'h00;
               report_in    = 1'b1;
               wipe_in      = '0;
               digit_in     = 4'(req_code - CODE_ZERO);
               x_in         = req_x;
               lo_in        = {1'b0, req_y};
               col_in       = 8'd0;
               page_in      = 6'(req_y >> 3);
               rd_ok_in     = rd_ok;
               mem_re       = (req_tuser == KIND_READ) && rd_ok;
               mem_raddr    = rd_idx[ADDR_W-1:0];
               if (req_tuser == KIND_DIGIT) begin
                  hi_in        = {1'b0, req_y};
                  page_last_in = 6'(req_y >> 3);
                  col_last_in  = 8'(GLYPH_COLS - 1);
               end else begin
                  hi_in        = bar_hi;
                  page_last_in = 6'((bar_hi - 9'd1) >> 3);
                  col_last_in  = req_width - 8'd1;
               end
            end
         end
         ST_LOOK: begin
            if (hit.page_ok && hit.in_range) begin
               mem_re  = 1'b1;
               addr_in = gen_addr;
               bits_in = hit.bits;
            end else if (hit.page_ok) begin
               if (col_ff == col_last_ff) begin
                  col_in  = 8'd0;
                  page_in = page_ff + 6'd1;
               end else begin
                  col_in = col_ff + 8'd1;
               end
            end
         end
         ST_MERGE: begin
            mem_we    = 1'b1;
            mem_waddr = addr_ff;
            mem_wdata = mem_q_ff | bits_ff;
            if (col_ff == col_last_ff) begin
               col_in  = 8'd0;
               page_in = page_ff + 6'd1;
            end else begin
               col_in = col_ff + 8'd1;
            end
         end
         ST_FETCH: begin
            data_in = rd_ok_ff ? mem_q_ff : 8'h00;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = data_ff;
               rsp_kind_in  = kind_ff;
            end
         end
         default: ;
      endcase
   end

   // Frame RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= frame_mem[mem_raddr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         report_ff    <= 1'b0;
         wipe_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         report_ff    <= report_in;
         wipe_ff      <= wipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      rd_ok_ff     <= rd_ok_in;
      data_ff      <= data_in;
      digit_ff     <= digit_in;
      x_ff         <= x_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      page_ff      <= page_in;
      page_last_ff <= page_last_in;
      col_ff       <= col_in;
      col_last_ff  <= col_last_in;
      addr_ff      <= addr_in;
      bits_ff      <= bits_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_kind_ff  <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   // Checks
   a_merge_after_look: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MERGE |-> $past(state_ff) == ST_LOOK)
      else $error("merge without a preceding lookup");

   a_walk_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOK |-> (col_ff <= col_last_ff) && (page_ff <= page_last_ff))
      else $error("walk ran past its last byte");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside completion");

   a_zero_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff != KIND_READ) |-> rsp_data_ff == 8'h00)
      else $error("non-read result carries data");

endmodule

>>> tb/sv/tb_mono_page_framebuffer_draw_unit.sv
// Self-checking testbench for the page-mode monochrome framebuffer draw unit.
`timescale 1ns / 1ps

module tb_mono_page_framebuffer_draw_unit;
   import mpfb_pkg::*;

   localparam int FB_W       = FB_WIDTH_DEF;
   localparam int FB_BYTES   = FB_WIDTH_DEF * FB_HEIGHT_DEF / 8;
   localparam int RAND_CMDS  = 1225;
   localparam int DRAIN_AT   = 700;     // command that waits for an empty pipeline
   localparam int HOLD_AT    = 400;     // results seen before the long receiver hold
   localparam int HOLD_LEN   = 300;
   localparam int CALM_TAIL  = 120;     // no idling over the last commands
   localparam int IDLE_LIMIT = 200000;  // largest bar plus clear sweep, several times over
   localparam int TAIL_WAIT  = 40;

   // One drawing command and the result it should produce
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] x_pos;
      logic [7:0] y_pos;
      logic [7:0] char_code;
      logic [7:0] bar_width;
      logic [7:0] bar_height;
      logic [7:0] bar_fill;
      logic [9:0] read_address;
      logic       drain_first;
   } draw_cmd_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] done_kind;
   } draw_result_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;

   // Predicted framebuffer contents and pending results
   logic [7:0]      fb_image [0:FB_BYTES-1];
   draw_cmd_type    cmd_q[$];
   draw_result_type expected_q[$];
   draw_cmd_type    cur_cmd = '0;

   int n_total = 0;
   int n_sent = 0;
   int n_rsp = 0;
   int n_err = 0;
   int n_lit_reads = 0;
   int kind_count [4] = '{0, 0, 0, 0};
   int gap_left = 0;
   int hold_left = 0;
   bit long_hold_done = 1'b0;
   int idle_cycles = 0;
   int last_x = 0;
   int last_y = 0;

   mono_page_framebuffer_draw_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // 6x8 digit font, column 0 in the top byte, bit 0 is the top row
   function automatic logic [7:0] digit_column(input int digit, input int col);
      logic [47:0] cols;
      case (digit)
         0:       cols = 48'h3E_51_49_45_3E_00;
         1:       cols = 48'h00_42_7F_40_00_00;
         2:       cols = 48'h42_61_51_49_46_00;
         3:       cols = 48'h21_41_45_4B_31_00;
         4:       cols = 48'h18_14_12_7F_10_00;
         5:       cols = 48'h27_45_45_45_39_00;
         6:       cols = 48'h3C_4A_49_49_30_00;
         7:       cols = 48'h01_71_09_05_03_00;
         8:       cols = 48'h36_49_49_49_36_00;
         9:       cols = 48'h06_49_49_29_1E_00;
         default: cols = 48'h0;
      endcase
      return cols[47 - 8 * col -: 8];
   endfunction

   // Apply one command to the predicted framebuffer and return its result
   function automatic draw_result_type draw_and_predict(input draw_cmd_type c);
      draw_result_type res;
      int base;
      int idx;
      int fill;
      int py;
      int shift;
      res.read_data = 8'h00;
      res.done_kind = c.kind;
      case (c.kind)
         KIND_CLEAR: begin
            for (int i = 0; i < FB_BYTES; i++) fb_image[i] = 8'h00;
         end
         KIND_DIGIT: begin
            if (c.char_code >= CODE_ZERO && c.char_code <= CODE_NINE) begin
               base  = (int'(c.y_pos) / 8) * FB_W + int'(c.x_pos);
               shift = int'(c.y_pos) % 8;
               for (int col = 0; col < GLYPH_COLS; col++) begin
                  idx = base + col;
                  // bits pushed past row 7 are lost, never carried to the next page
                  if (idx < FB_BYTES)
                     fb_image[idx] = fb_image[idx] | 8'((int'(digit_column(
                        int'(c.char_code - CODE_ZERO), col)) << shift) & 255);
               end
            end
         end
         KIND_BAR: begin
            fill = (c.bar_fill > c.bar_height) ? int'(c.bar_height) : int'(c.bar_fill);
            for (int i = 0; i < int'(c.bar_width); i++) begin
               for (int r = 0; r < fill; r++) begin
                  py  = int'(c.y_pos) + r;
                  idx = (py / 8) * FB_W + int'(c.x_pos) + i;
                  if (idx < FB_BYTES) fb_image[idx] = fb_image[idx] | 8'(1 << (py % 8));
               end
            end
         end
         default: begin
            if (int'(c.read_address) < FB_BYTES) res.read_data = fb_image[c.read_address];
         end
      endcase
      return res;
   endfunction

   // Directed command with the unused fields given explicitly
   function automatic draw_cmd_type make_cmd(input logic [1:0] kind, input int x, input int y,
                                            input int code, input int w, input int h,
                                            input int fill, input int addr);
      draw_cmd_type c;
      c.kind         = kind;
      c.x_pos        = 8'(x);
      c.y_pos        = 8'(y);
      c.char_code    = 8'(code);
      c.bar_width    = 8'(w);
      c.bar_height   = 8'(h);
      c.bar_fill     = 8'(fill);
      c.read_address = 10'(addr);
      c.drain_first  = 1'b0;
      return c;
   endfunction

   // Random command: draws and a few clears, and reads that mostly land near the last drawn spot
   function automatic draw_cmd_type random_cmd();
      draw_cmd_type c;
      int sel;
      c.kind         = 2'($urandom_range(0, 3));
      c.x_pos        = 8'($urandom_range(0, 255));
      c.y_pos        = 8'($urandom_range(0, 255));
      c.char_code    = 8'($urandom_range(0, 255));
      c.bar_width    = 8'($urandom_range(0, 255));
      c.bar_height   = 8'($urandom_range(0, 255));
      c.bar_fill     = 8'($urandom_range(0, 255));
      c.read_address = 10'($urandom_range(0, 1023));
      c.drain_first  = 1'b0;
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
         c.kind = KIND_CLEAR;
      end else if (sel < 50) begin
         c.kind = (sel < 28) ? KIND_DIGIT : KIND_BAR;
         if ($urandom_range(0, 3) != 0) begin
            c.x_pos = 8'($urandom_range(0, FB_W - 1));
            c.y_pos = 8'($urandom_range(0, FB_HEIGHT_DEF - 1));
         end
         if (c.kind == KIND_DIGIT && $urandom_range(0, 9) != 0)
            c.char_code = CODE_ZERO + 8'($urandom_range(0, 9));
         // keep most bars small, the odd one anywhere up to full size
         if (c.kind == KIND_BAR && $urandom_range(0, 49) != 0) begin
            c.bar_width  = 8'($urandom_range(0, 12));
            c.bar_height = 8'($urandom_range(0, 16));
            c.bar_fill   = 8'($urandom_range(0, 20));
         end
         last_x = int'(c.x_pos);
         last_y = int'(c.y_pos);
      end else begin
         c.kind = KIND_READ;
         if ($urandom_range(0, 2) != 0)
            c.read_address = 10'((last_y / 8 + $urandom_range(0, 1)) * FB_W + last_x
                                 + $urandom_range(0, 13));
      end
      return c;
   endfunction

   // Stimulus, reset and end of run
   initial begin : stim_proc
      for (int i = 0; i < FB_BYTES; i++) fb_image[i] = 8'h00;

      cmd_q.push_back(make_cmd(KIND_READ,  17, 33, 200, 9, 9, 9, 0));
      cmd_q.push_back(make_cmd(KIND_READ,  0, 0, 0, 0, 0, 0, 1023));
      cmd_q.push_back(make_cmd(KIND_DIGIT, 0, 0, CODE_ZERO + 8, 255, 255, 255, 1023));
      cmd_q.push_back(make_cmd(KIND_READ,  0, 0, 0, 0, 0, 0, 2));
      // shifted glyph, rows below the page are cut off
      cmd_q.push_back(make_cmd(KIND_DIGIT, 20, 3, CODE_ZERO, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(KIND_READ,  0, 0, 0, 0, 0, 0, 21));
      cmd_q.push_back(make_cmd(KIND_READ,  0, 0, 0, 0, 0, 0, FB_W + 21));
      // codes just outside the digit range and the top code draw nothing
      cmd_q.push_back(make_cmd(KIND_DIGIT, 40, 0, CODE_ZERO - 1, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(KIND_DIGIT, 40, 0, CODE_NINE + 1, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(KIND_DIGIT, 40, 0, 255, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(KIND_READ,  0, 0, 0, 0, 0, 0, 41));
      // glyph partly past the end of the store, then entirely past it
      cmd_q.push_back(make_cmd(KIND_DIGIT, 124, 61, CODE_ZERO + 1, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(KIND_DIGIT, 255, 255, CODE_NINE, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(KIND_READ,  0, 0, 0, 0, 0, 0, FB_BYTES - 1));
      // column offset runs into the next linear index without wrapping
      cmd_q.push_back(make_cmd(KIND_DIGIT, 125, 0, CODE_ZERO + 7, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(KIND_READ,  0, 0, 0, 0, 0, 0, FB_W));
      // fill above height, then zero width, zero height and zero fill
      cmd_q.push_back(make_cmd(KIND_BAR,   10, 5, 0, 3, 4, 200, 0));
      cmd_q.push_back(make_cmd(KIND_BAR,   60, 0, 0, 0, 8, 8, 0));
      cmd_q.push_back(make_cmd(KIND_BAR,   60, 0, 0, 8, 0, 8, 0));
      cmd_q.push_back(make_cmd(KIND_BAR,   60, 0, 0, 8, 8, 0, 0));
      cmd_q.push_back(make_cmd(KIND_READ,  0, 0, 0, 0, 0, 0, FB_W + 11));
      cmd_q.push_back(make_cmd(KIND_BAR,   255, 255, 0, 255, 255, 255, 0));
      cmd_q.push_back(make_cmd(KIND_BAR,   0, 56, 0, 128, 8, 8, 0));
      cmd_q.push_back(make_cmd(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
      cmd_q.push_back(make_cmd(KIND_READ,  0, 0, 0, 0, 0, 0, 900));

      for (int i = 0; i < RAND_CMDS; i++) cmd_q.push_back(random_cmd());
      cmd_q[DRAIN_AT].drain_first = 1'b1;
      n_total = cmd_q.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (cmd_q.size() > 0 || req_tvalid || expected_q.size() > 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      $display("Sent %0d commands: %0d clear, %0d digit, %0d bar, %0d read", n_sent,
               kind_count[KIND_CLEAR], kind_count[KIND_DIGIT], kind_count[KIND_BAR],
               kind_count[KIND_READ]);
      $display("Checked %0d results, %0d reads returned lit pixels", n_rsp, n_lit_reads);
      if (n_err == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Command driver with random gaps between transactions
   always @(posedge clock) begin : drive_proc
      logic take;
      logic offer;
      bit   idle_ok;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         take    = req_tvalid && req_tready;
         idle_ok = ((n_sent / 150) % 4 != 3) && (n_sent < n_total - CALM_TAIL);
         if (take) begin
            expected_q.push_back(draw_and_predict(cur_cmd));
            kind_count[cur_cmd.kind]++;
            n_sent++;
            if (idle_ok && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 13);
         end
         offer = req_tvalid && !take;
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_q.size() > 0 &&
                         !(cmd_q[0].drain_first && (take || expected_q.size() > 0))) begin
               cur_cmd = cmd_q.pop_front();
               offer   = 1'b1;
            end
         end
         req_tvalid <= offer;
         req_tdata  <= {6'b0, cur_cmd.read_address, cur_cmd.bar_fill, cur_cmd.bar_height,
                        cur_cmd.bar_width, cur_cmd.char_code, cur_cmd.y_pos, cur_cmd.x_pos};
         req_tuser  <= cur_cmd.kind;
      end
   end

   // Result ready: short random holds plus one long hold that backs up the unit
   always @(posedge clock) begin : ready_proc
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (!long_hold_done && n_rsp >= HOLD_AT) begin
            hold_left      = HOLD_LEN;
            long_hold_done = 1'b1;
         end else if (hold_left == 0 && (n_rsp / 150) % 4 != 1 &&
                      n_rsp < n_total - CALM_TAIL && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(1, 13);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Result monitor: compare each transaction with the oldest prediction
   always @(posedge clock) begin : check_proc
      draw_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_rsp++;
         if (expected_q.size() == 0) begin
            $error("result with no command outstanding: read_data 0x%02h, done_kind %0d",
                   rsp_tdata, rsp_tuser);
            n_err++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata !== want.read_data) begin
               $error("read_data: expected 0x%02h, got 0x%02h", want.read_data, rsp_tdata);
               n_err++;
            end
            if (rsp_tuser !== want.done_kind) begin
               $error("done_kind: expected %0d, got %0d", want.done_kind, rsp_tuser);
               n_err++;
            end
            if (want.done_kind == KIND_READ && want.read_data != 8'h00) n_lit_reads++;
         end
      end
   end

   // Watchdog on cycles with no transaction on either side
   always @(posedge clock) begin : watchdog_proc
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $error("timeout: no transaction for %0d cycles, %0d results outstanding",
                   idle_cycles, expected_q.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

endmodule
